>>> rtl/cpd_pkg.sv
`default_nettype none

package cpd_pkg;

   // Packet geometry and framing constants.
   localparam int unsigned PACKET_BYTES = 19;
   localparam int unsigned FILL_WIDTH   = 5;
   localparam logic [7:0]  SYNC_BYTE    = 8'hC3;

   // Result status codes.
   localparam logic [1:0] STATUS_NEED_MORE = 2'd0;
   localparam logic [1:0] STATUS_ACCEPTED  = 2'd1;
   localparam logic [1:0] STATUS_RESYNCED  = 2'd2;
   localparam logic [1:0] STATUS_CLEARED   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_byte;     // store the request byte and bump the fill count
      logic load_need_more; // publish a need-more result
      logic load_accept;    // publish the decoded packet and empty the window
      logic save_sum;       // capture the received checksum before shifting
      logic shift;          // drop the byte at position zero
      logic load_resync;    // drop position zero and publish a resync result
      logic load_clear;     // empty the window and publish a cleared result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;     // the result register can take a new result
      logic fill_is_last; // the next byte completes the window
      logic check_ok;     // checksum matches and header is the sync byte
      logic next_is_sync; // position one holds the sync byte
      logic fill_is_two;  // only two bytes remain in the window
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/cpd_controller.sv
`default_nettype none

module cpd_controller
   import cpd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // Requests are taken only while idle and the result register has room.
   assign req_stall = (state_ff != ST_IDLE) || !stat.out_free;
   assign accept    = req_valid && !req_stall;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.write_byte = 1'b1;
               if (stat.fill_is_last) begin
                  state_in = ST_EVAL;
               end else begin
                  cmd.load_need_more = 1'b1;
               end
            end
         end
         ST_EVAL: begin
            if (stat.check_ok) begin
               if (stat.out_free) begin
                  cmd.load_accept = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.save_sum = 1'b1;
               state_in     = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (stat.next_is_sync) begin
               if (stat.out_free) begin
                  cmd.load_resync = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (stat.fill_is_two) begin
               if (stat.out_free) begin
                  cmd.load_clear = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.shift = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A full window is always evaluated right after the byte that filled it.
   assert property (@(posedge clock) disable iff (reset)
      (accept && stat.fill_is_last) |=> (state_ff == ST_EVAL))
      else $error("full window was not evaluated");

   // A shift is never issued from the idle state.
   assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> (state_ff == ST_SHIFT))
      else $error("shift issued outside the resync search");

   // Leaving the search always publishes a result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && state_in == ST_IDLE) |-> (cmd.load_resync || cmd.load_clear))
      else $error("resync search ended without a result");

endmodule

`default_nettype wire

>>> rtl/cpd_datapath.sv
`default_nettype none

module cpd_datapath
   import cpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_rx_byte,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_header,
   output logic [15:0]      rsp_speed,
   output logic [31:0]      rsp_yaw_bits,
   output logic [31:0]      rsp_pitch_bits,
   output logic [31:0]      rsp_roll_bits,
   output logic [31:0]      rsp_rx_checksum,
   output logic [4:0]       rsp_bytes_held
);

   localparam logic [FILL_WIDTH-1:0] FILL_LAST = FILL_WIDTH'(PACKET_BYTES - 1);
   localparam logic [FILL_WIDTH-1:0] FILL_TWO  = FILL_WIDTH'(2);
   localparam logic [FILL_WIDTH-1:0] FILL_ONE  = FILL_WIDTH'(1);

   logic [7:0]            window_ff [PACKET_BYTES];
   logic [FILL_WIDTH-1:0] fill_ff;
   logic [FILL_WIDTH-1:0] fill_in;
   logic [31:0]           sum_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [1:0]            status_ff;
   logic [7:0]            header_ff;
   logic [15:0]           speed_ff;
   logic [31:0]           yaw_ff;
   logic [31:0]           pitch_ff;
   logic [31:0]           roll_ff;
   logic [31:0]           checksum_ff;
   logic [4:0]            held_ff;

   logic [15:0] speed_word;
   logic [31:0] yaw_word;
   logic [31:0] pitch_word;
   logic [31:0] roll_word;
   logic [31:0] rx_word;
   logic [31:0] calc_word;
   logic        shift_now;
   logic        load_any;

   // Big-endian fields of the window at their fixed positions.
   assign speed_word = {window_ff[1], window_ff[2]};
   assign yaw_word   = {window_ff[3], window_ff[4], window_ff[5], window_ff[6]};
   assign pitch_word = {window_ff[7], window_ff[8], window_ff[9], window_ff[10]};
   assign roll_word  = {window_ff[11], window_ff[12], window_ff[13], window_ff[14]};
   assign rx_word    = {window_ff[15], window_ff[16], window_ff[17], window_ff[18]};
   assign calc_word  = {24'd0, window_ff[0]} ^ {16'd0, speed_word}
                     ^ yaw_word ^ pitch_word ^ roll_word;

   // Status back to the controller.
   assign stat.out_free     = !rsp_valid_ff || !rsp_stall;
   assign stat.fill_is_last = (fill_ff == FILL_LAST);
   assign stat.check_ok     = (calc_word == rx_word) && (window_ff[0] == SYNC_BYTE);
   assign stat.next_is_sync = (window_ff[1] == SYNC_BYTE);
   assign stat.fill_is_two  = (fill_ff == FILL_TWO);

   assign shift_now = cmd.shift || cmd.load_resync;
   assign load_any  = cmd.load_need_more || cmd.load_accept || cmd.load_resync
                    || cmd.load_clear;

   // Window storage: byte writes at the fill position, one-place shifts on resync.
   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         window_ff[fill_ff] <= req_rx_byte;
      end else if (shift_now) begin
         for (int i = 0; i < PACKET_BYTES - 1; i++) begin
            window_ff[i] <= window_ff[i + 1];
         end
      end
   end

   // Fill count.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.write_byte) begin
         fill_in = fill_ff + FILL_ONE;
      end else if (shift_now) begin
         fill_in = fill_ff - FILL_ONE;
      end else if (cmd.load_accept || cmd.load_clear) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // The received checksum is kept before the search shifts it away.
   always_ff @(posedge clock) begin
      if (cmd.save_sum) begin
         sum_ff <= rx_word;
      end
   end

   // Result register valid flag.
   assign rsp_valid_in = load_any || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load_any) begin
         status_ff   <= STATUS_NEED_MORE;
         header_ff   <= '0;
         speed_ff    <= '0;
         yaw_ff      <= '0;
         pitch_ff    <= '0;
         roll_ff     <= '0;
         checksum_ff <= '0;
         held_ff     <= fill_in;
         if (cmd.load_accept) begin
            status_ff   <= STATUS_ACCEPTED;
            header_ff   <= window_ff[0];
            speed_ff    <= speed_word;
            yaw_ff      <= yaw_word;
            pitch_ff    <= pitch_word;
            roll_ff     <= roll_word;
            checksum_ff <= rx_word;
         end else if (cmd.load_resync) begin
            status_ff   <= STATUS_RESYNCED;
            checksum_ff <= sum_ff;
         end else if (cmd.load_clear) begin
            status_ff   <= STATUS_CLEARED;
            checksum_ff <= sum_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_header      = header_ff;
   assign rsp_speed       = speed_ff;
   assign rsp_yaw_bits    = yaw_ff;
   assign rsp_pitch_bits  = pitch_ff;
   assign rsp_roll_bits   = roll_ff;
   assign rsp_rx_checksum = checksum_ff;
   assign rsp_bytes_held  = held_ff;

   // The window never holds more than one packet.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_WIDTH'(PACKET_BYTES))
      else $error("fill count beyond window size");

   // A plain shift only happens while more than two bytes remain.
   assert property (@(posedge clock) disable iff (reset)
      cmd.shift |-> (fill_ff > FILL_TWO))
      else $error("shift with too few bytes held");

   // Header, speed and angle fields stay zero unless a packet was accepted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_ACCEPTED) |-> (yaw_ff == '0 && header_ff == '0))
      else $error("payload nonzero on a non-accepted result");

   // A new result is never loaded over one that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      load_any |-> stat.out_free)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/control_packet_deframer_core.sv
// A byte that does not complete the window gives its result in the cycle after acceptance.
// A completing byte is evaluated first: an accepted packet then gives its result, and a
// checksum or header failure starts a resync search that shifts the window one byte per cycle.
// Throughput: one byte per cycle while the window fills and the result has room; no request
// during evaluation or search. Reset clears the fill count and valid flag, not the window bytes.
`default_nettype none

module control_packet_deframer_core
   import cpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_header,
   output logic [15:0]      rsp_speed,
   output logic [31:0]      rsp_yaw_bits,
   output logic [31:0]      rsp_pitch_bits,
   output logic [31:0]      rsp_roll_bits,
   output logic [31:0]      rsp_rx_checksum,
   output logic [4:0]       rsp_bytes_held
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencing of fill, evaluation and resync search.
   cpd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Window, checksum logic and result register.
   cpd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_header      (rsp_header),
      .rsp_speed       (rsp_speed),
      .rsp_yaw_bits    (rsp_yaw_bits),
      .rsp_pitch_bits  (rsp_pitch_bits),
      .rsp_roll_bits   (rsp_roll_bits),
      .rsp_rx_checksum (rsp_rx_checksum),
      .rsp_bytes_held  (rsp_bytes_held)
   );

endmodule

`default_nettype wire
